// ===== src/dmm_lcd_frame_decoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// dmm_lcd_frame_decoder_unit_defines.svh
// Assertion macros shared by the frame decoder checks.
// ----------------------------------------------------------------------------
`ifndef DMM_LCD_FRAME_DECODER_UNIT_DEFINES_SVH
`define DMM_LCD_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DMM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define DMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dmm_lcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dmm_lcd_pkg
// Types, constants and the segment decode table of the LCD frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dmm_lcd_pkg;

   localparam int BYTE_W     = 8;
   localparam int NIB_W      = 4;
   localparam int NIB_DEPTH  = 13;
   localparam int SNAP_NIBS  = 12;
   localparam int COUNT_W    = 4;
   localparam int MANT_W     = 14;
   localparam int EXPO_W     = 4;
   localparam int UNIT_W     = 2;
   localparam int DIGIT_W    = 4;

   localparam logic [NIB_W-1:0]   TAG_START = 4'h1;
   localparam logic [NIB_W-1:0]   TAG_END   = 4'hE;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
   localparam logic [COUNT_W-1:0] COUNT_OK  = 4'd13;   // fourteen with the end byte
   localparam logic [COUNT_W-1:0] NIB_LAST  = 4'd13;

   localparam logic [UNIT_W-1:0] UNIT_UNKNOWN = 2'd0;
   localparam logic [UNIT_W-1:0] UNIT_VOLT    = 2'd1;
   localparam logic [UNIT_W-1:0] UNIT_AMP     = 2'd2;

   // nibs[k] holds frame position k+1
   typedef struct packed {
      logic                            frame_ok;
      logic [SNAP_NIBS-1:0][NIB_W-1:0] nibs;
   } frame_snap_type;

   // field order matches the packed reading used for the change test
   typedef struct packed {
      logic              digit_error;
      logic              negative;
      logic [MANT_W-1:0] mantissa;
      logic [EXPO_W-1:0] decimal_exponent;
      logic [UNIT_W-1:0] unit_code;
   } reading_type;

   typedef struct packed {
      logic               bad;
      logic [DIGIT_W-1:0] value;
   } digit_type;

   function automatic digit_type decode_digit(input logic [2:0] seg_a,
                                              input logic [3:0] seg_b);
      digit_type d;
      d.bad = 1'b0;
      case ({seg_a, seg_b})
         {3'h7, 4'hD}: d.value = 4'd0;
         {3'h0, 4'h5}: d.value = 4'd1;
         {3'h5, 4'hB}: d.value = 4'd2;
         {3'h1, 4'hF}: d.value = 4'd3;
         {3'h2, 4'h7}: d.value = 4'd4;
         {3'h3, 4'hE}: d.value = 4'd5;
         {3'h7, 4'hE}: d.value = 4'd6;
         {3'h1, 4'h5}: d.value = 4'd7;
         {3'h7, 4'hF}: d.value = 4'd8;
         {3'h3, 4'hF}: d.value = 4'd9;
         default: begin
            d.value = 4'd0;
            d.bad   = 1'b1;
         end
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== src/dmm_lcd_if.sv =====
// ----------------------------------------------------------------------------
// dmm_lcd_req_if / dmm_lcd_rsp_if
// Valid/ready channels for received bytes and decoded readings.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmm_lcd_req_if import dmm_lcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dmm_lcd_rsp_if import dmm_lcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              frame_ok;
   logic              digit_error;
   logic              negative;
   logic [MANT_W-1:0] mantissa;
   logic [EXPO_W-1:0] decimal_exponent;
   logic [UNIT_W-1:0] unit_code;
   logic              changed;

   modport source (output valid, output frame_ok, output digit_error, output negative,
                   output mantissa, output decimal_exponent, output unit_code,
                   output changed, input ready);
   modport sink   (input valid, input frame_ok, input digit_error, input negative,
                   input mantissa, input decimal_exponent, input unit_code,
                   input changed, output ready);
endinterface

`default_nettype wire

// ===== src/dmm_lcd_capture.sv =====
// ----------------------------------------------------------------------------
// dmm_lcd_capture
// Nibble store and byte counter; snapshots the frame when an end byte lands.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_lcd_capture import dmm_lcd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire logic [BYTE_W-1:0] in_byte,
   output      logic              snap_valid,
   input  wire logic              snap_take,
   output      frame_snap_type    snap
);

   logic [NIB_W-1:0]   nib_ff [NIB_DEPTH];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               snap_valid_ff, snap_valid_in;
   frame_snap_type     snap_ff, snap_in;

   logic               fire;
   logic [NIB_W-1:0]   tag;
   logic [NIB_W-1:0]   low;
   logic               is_start;
   logic               is_end;
   logic               wr_en;

   assign tag      = in_byte[BYTE_W-1:NIB_W];
   assign low      = in_byte[NIB_W-1:0];
   assign is_start = (tag == TAG_START);
   assign is_end   = (tag == TAG_END);
   assign in_ready = !snap_valid_ff || snap_take;
   assign fire     = in_valid && in_ready;
   assign wr_en    = fire && !is_start && (count_ff < NIB_LAST);

   always_comb begin
      count_in = count_ff;
      if (fire) begin
         if (is_start) begin
            count_in = 4'd1;
         end else if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 4'd1;
         end
      end
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      snap_in       = snap_ff;
      if (fire && is_end) begin
         snap_valid_in    = 1'b1;
         snap_in.frame_ok = (count_ff == COUNT_OK);
         for (int k = 0; k < SNAP_NIBS; k++) begin
            snap_in.nibs[k] = nib_ff[k+1];
         end
      end else if (snap_take) begin
         snap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      if (fire && is_start) begin
         nib_ff[0] <= low;
      end else if (wr_en) begin
         nib_ff[count_ff] <= low;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

`default_nettype wire

// ===== src/dmm_lcd_decode.sv =====
// ----------------------------------------------------------------------------
// dmm_lcd_decode
// Segment, sign, exponent and unit decode of one captured frame.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_lcd_decode import dmm_lcd_pkg::*; (
   input  wire frame_snap_type snap,
   output      reading_type    reading
);

   digit_type         dig [4];
   logic [MANT_W-1:0] mant;
   logic [EXPO_W-1:0] expo;
   logic [UNIT_W-1:0] unit;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dig[i] = decode_digit(snap.nibs[2*i][2:0], snap.nibs[2*i+1]);
      end
   end

   assign mant = MANT_W'(dig[0].value) * MANT_W'(1000)
               + MANT_W'(dig[1].value) * MANT_W'(100)
               + MANT_W'(dig[2].value) * MANT_W'(10)
               + MANT_W'(dig[3].value);

   // decimal points at positions 3, 5, 7; micro at 9, milli at 10
   assign expo = (snap.nibs[2][3] ? 4'd3 : 4'd0)
               + (snap.nibs[4][3] ? 4'd2 : 4'd0)
               + (snap.nibs[6][3] ? 4'd1 : 4'd0)
               + (snap.nibs[8][3] ? 4'd3 : 4'd0)
               + (snap.nibs[9][3] ? 4'd3 : 4'd0);

   always_comb begin
      if (snap.nibs[11][3]) begin
         unit = UNIT_AMP;
      end else if (snap.nibs[11][2]) begin
         unit = UNIT_VOLT;
      end else begin
         unit = UNIT_UNKNOWN;
      end
   end

   always_comb begin
      reading = '0;
      if (snap.frame_ok) begin
         reading.digit_error      = dig[0].bad | dig[1].bad | dig[2].bad | dig[3].bad;
         reading.negative         = snap.nibs[0][3];
         reading.mantissa         = mant;
         reading.decimal_exponent = expo;
         reading.unit_code        = unit;
      end
   end

endmodule

`default_nettype wire

// ===== src/dmm_lcd_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// dmm_lcd_frame_decoder_unit
// An end byte's result passes through the snapshot register, then the result register.
// Throughput: one byte per cycle; the snapshot and result registers decouple
// the channels, so a held result stalls input only once both are full.
// Reset clears the byte count, the last reading and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_lcd_frame_decoder_unit import dmm_lcd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   dmm_lcd_req_if.sink req_link,
   dmm_lcd_rsp_if.source rsp_link
);

   logic           snap_valid;
   logic           snap_take;
   frame_snap_type snap;
   reading_type    reading;

   logic           rsp_valid_ff, rsp_valid_in;
   reading_type    rsp_reading_ff;
   logic           rsp_ok_ff;
   logic           rsp_changed_ff;
   reading_type    last_ff, last_in;
   logic           have_last_ff, have_last_in;
   logic           changed;
   logic           advance;

   dmm_lcd_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_link.valid),
      .in_ready   (req_link.ready),
      .in_byte    (req_link.rx_byte),
      .snap_valid (snap_valid),
      .snap_take  (snap_take),
      .snap       (snap)
   );

   dmm_lcd_decode u_decode (
      .snap    (snap),
      .reading (reading)
   );

   assign snap_take = !rsp_valid_ff || rsp_link.ready;
   assign advance   = snap_valid && snap_take;
   assign changed   = snap.frame_ok && (!have_last_ff || (reading != last_ff));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      have_last_in = have_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (snap.frame_ok) begin
            last_in      = reading;
            have_last_in = 1'b1;
         end
      end else if (rsp_link.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         have_last_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         have_last_ff <= have_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_reading_ff <= reading;
         rsp_ok_ff      <= snap.frame_ok;
         rsp_changed_ff <= changed;
      end
   end

   assign rsp_link.valid            = rsp_valid_ff;
   assign rsp_link.frame_ok         = rsp_ok_ff;
   assign rsp_link.digit_error      = rsp_reading_ff.digit_error;
   assign rsp_link.negative         = rsp_reading_ff.negative;
   assign rsp_link.mantissa         = rsp_reading_ff.mantissa;
   assign rsp_link.decimal_exponent = rsp_reading_ff.decimal_exponent;
   assign rsp_link.unit_code        = rsp_reading_ff.unit_code;
   assign rsp_link.changed          = rsp_changed_ff;

endmodule

`default_nettype wire

// ===== src/dmm_lcd_checker.sv =====
// ----------------------------------------------------------------------------
// dmm_lcd_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dmm_lcd_frame_decoder_unit_defines.svh"

module dmm_lcd_checker import dmm_lcd_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_frame_ok,
   input wire logic              rsp_digit_error,
   input wire logic              rsp_negative,
   input wire logic [MANT_W-1:0] rsp_mantissa,
   input wire logic [EXPO_W-1:0] rsp_decimal_exponent,
   input wire logic [UNIT_W-1:0] rsp_unit_code,
   input wire logic              rsp_changed
);

   // a stalled transaction stays valid and keeps its mantissa, frame_ok and changed flag
   `DMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_mantissa) && $stable(rsp_frame_ok) && $stable(rsp_changed),
      "rsp payload changed while stalled")

   // a bad frame length carries an all-zero reading
   `DMM_ASSERT_IMPLY(a_bad_frame_zero, clock, reset, rsp_valid && !rsp_frame_ok,
      !rsp_digit_error && !rsp_negative && rsp_mantissa == '0 &&
      rsp_decimal_exponent == '0 && rsp_unit_code == UNIT_UNKNOWN && !rsp_changed,
      "bad frame with non-zero reading")

   `DMM_ASSERT_IMPLY(a_mant_range, clock, reset, rsp_valid,
      rsp_mantissa <= MANT_W'(9999), "mantissa above 9999")

   `DMM_ASSERT_IMPLY(a_expo_unit_range, clock, reset, rsp_valid,
      rsp_decimal_exponent <= EXPO_W'(12) &&
      (rsp_unit_code == UNIT_UNKNOWN || rsp_unit_code == UNIT_VOLT ||
       rsp_unit_code == UNIT_AMP),
      "exponent or unit out of range")

endmodule

bind dmm_lcd_frame_decoder_unit dmm_lcd_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_link.valid),
   .rsp_ready            (rsp_link.ready),
   .rsp_frame_ok         (rsp_link.frame_ok),
   .rsp_digit_error      (rsp_link.digit_error),
   .rsp_negative         (rsp_link.negative),
   .rsp_mantissa         (rsp_link.mantissa),
   .rsp_decimal_exponent (rsp_link.decimal_exponent),
   .rsp_unit_code        (rsp_link.unit_code),
   .rsp_changed          (rsp_link.changed)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Bench for the LCD frame decoder: a byte-level predictor tracks the frame
// store and the last valid reading. Decoded readings are checked against it
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import dmm_lcd_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 150;

   typedef enum int {FRAME_FULL, FRAME_SHORT, FRAME_LONG} frame_shape_type;
   typedef enum int {PACE_FULL, PACE_COIN, PACE_MOSTLY, PACE_PERIODIC} rx_pace_type;

   typedef struct packed {
      logic                     frame_ok;
      dmm_lcd_pkg::reading_type rd;
      logic                     changed;
   } reading_out_type;

   // {a, b} segment nibbles of each digit
   function automatic logic [6:0] seg_pattern(input int d);
      case (d)
         0: return {3'h7, 4'hD};
         1: return {3'h0, 4'h5};
         2: return {3'h5, 4'hB};
         3: return {3'h1, 4'hF};
         4: return {3'h2, 4'h7};
         5: return {3'h3, 4'hE};
         6: return {3'h7, 4'hE};
         7: return {3'h1, 4'h5};
         8: return {3'h7, 4'hF};
         default: return {3'h3, 4'hF};
      endcase
   endfunction

   class reading_tracker;

      logic [3:0]               nib_store [13];
      logic [3:0]               byte_cnt;
      dmm_lcd_pkg::reading_type last_rd;
      bit                       have_last;
      reading_out_type          due [$];
      int                       faults;

      function new();
         byte_cnt  = '0;
         last_rd   = '0;
         have_last = 1'b0;
         faults    = 0;
         foreach (nib_store[k]) nib_store[k] = '0;
      endfunction

      function void keep_nibble(input logic [3:0] low);
         if (byte_cnt < dmm_lcd_pkg::NIB_DEPTH) nib_store[byte_cnt] = low;
         if (byte_cnt != dmm_lcd_pkg::COUNT_MAX) byte_cnt++;
      endfunction

      function void take_byte(input logic [7:0] b);
         reading_out_type want;
         int              mant;
         int              expo;
         int              i;
         int              d;
         bit              hit;
         want = '0;
         if (b[7:4] == dmm_lcd_pkg::TAG_START) begin
            nib_store[0] = b[3:0];
            byte_cnt     = 4'd1;
            return;
         end
         if (b[7:4] != dmm_lcd_pkg::TAG_END) begin
            keep_nibble(b[3:0]);
            return;
         end
         want.frame_ok = (byte_cnt == dmm_lcd_pkg::COUNT_OK);
         keep_nibble(b[3:0]);
         if (want.frame_ok) begin
            mant = 0;
            for (i = 0; i < 4; i++) begin
               hit = 1'b0;
               for (d = 0; d < 10; d++) begin
                  if (!hit && seg_pattern(d) == {nib_store[1+2*i][2:0], nib_store[2+2*i]})
                  begin
                     hit  = 1'b1;
                     mant = mant * 10 + d;
                  end
               end
               if (!hit) begin
                  want.rd.digit_error = 1'b1;
                  mant = mant * 10;
               end
            end
            expo = 0;
            if (nib_store[3][3])  expo += 3;
            if (nib_store[5][3])  expo += 2;
            if (nib_store[7][3])  expo += 1;
            if (nib_store[10][3]) expo += 3;   // milli
            if (nib_store[9][3])  expo += 3;   // micro
            want.rd.negative         = nib_store[1][3];
            want.rd.mantissa         = mant[13:0];
            want.rd.decimal_exponent = expo[3:0];
            if (nib_store[12][3])      want.rd.unit_code = dmm_lcd_pkg::UNIT_AMP;
            else if (nib_store[12][2]) want.rd.unit_code = dmm_lcd_pkg::UNIT_VOLT;
            else                       want.rd.unit_code = dmm_lcd_pkg::UNIT_UNKNOWN;
            want.changed = !have_last || (want.rd != last_rd);
            last_rd   = want.rd;
            have_last = 1'b1;
         end
         due.push_back(want);
      endfunction

      function string show(input reading_out_type r);
         return $sformatf("ok=%0b err=%0b neg=%0b mant=%0d exp=%0d unit=%0d chg=%0b",
                          r.frame_ok, r.rd.digit_error, r.rd.negative, r.rd.mantissa,
                          r.rd.decimal_exponent, r.rd.unit_code, r.changed);
      endfunction

      function void check_reading(input reading_out_type got);
         reading_out_type want;
         bit              bad;
         if (due.size() == 0) begin
            faults++;
            if (faults <= 10) $display("reading with no transaction pending: %s", show(got));
            return;
         end
         want = due.pop_front();
         bad = (want.frame_ok != got.frame_ok)
            || (want.rd.digit_error != got.rd.digit_error)
            || (want.rd.negative != got.rd.negative)
            || (want.rd.mantissa != got.rd.mantissa)
            || (want.rd.decimal_exponent != got.rd.decimal_exponent)
            || (want.rd.unit_code != got.rd.unit_code)
            || (want.changed != got.changed);
         if (bad) begin
            faults++;
            if (faults <= 10) begin
               $display("wrong reading: expected %s", show(want));
               $display("               actual   %s", show(got));
            end
         end
      endfunction

   endclass

   logic clock;
   logic reset;

   dmm_lcd_req_if req_link ();
   dmm_lcd_rsp_if rsp_link ();

   dmm_lcd_frame_decoder_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_link (req_link),
      .rsp_link (rsp_link)
   );

   reading_tracker  tracker;
   reading_out_type seen;

   int  bytes_taken = 0;
   int  bytes_sent  = 0;
   int  burst_left  = 0;
   bit  hold_active = 1'b0;

   // planned content of positions 0..12 of the next frame
   logic [3:0] frame_plan [13];
   int         plan_digit [4];
   bit         plan_neg;
   logic [2:0] plan_dp;
   bit         plan_micro;
   bit         plan_milli;
   logic [1:0] plan_unit;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_link.valid && req_link.ready) begin
            tracker.take_byte(req_link.rx_byte);
            bytes_taken++;
         end
         if (rsp_link.valid && rsp_link.ready) begin
            seen.frame_ok            = rsp_link.frame_ok;
            seen.rd.digit_error      = rsp_link.digit_error;
            seen.rd.negative         = rsp_link.negative;
            seen.rd.mantissa         = rsp_link.mantissa;
            seen.rd.decimal_exponent = rsp_link.decimal_exponent;
            seen.rd.unit_code        = rsp_link.unit_code;
            seen.changed             = rsp_link.changed;
            tracker.check_reading(seen);
         end
      end
   end

   // watchdog: cycles in which neither channel moves a transaction
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_link.valid && req_link.ready) || (rsp_link.valid && rsp_link.ready))
            idle = 0;
         else
            idle++;
      end
      $display("dmm_lcd_frame_decoder_unit: mismatch");
      $finish;
   end

   // result side: pace changes now and then, plus one long hold-off
   initial begin
      rx_pace_type pace;
      int          pace_left;
      int          phase;
      bit          hold_done;
      pace      = PACE_FULL;
      pace_left = 0;
      phase     = 0;
      hold_done = 1'b0;
      rsp_link.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && bytes_taken >= 300) begin
            hold_active = 1'b1;
            rsp_link.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active = 1'b0;
            hold_done   = 1'b1;
            rsp_link.ready <= 1'b1;
         end else begin
            if (pace_left == 0) begin
               pace      = rx_pace_type'($urandom_range(3, 0));
               pace_left = $urandom_range(200, 30);
            end
            pace_left--;
            phase++;
            case (pace)
               PACE_FULL:     rsp_link.ready <= 1'b1;
               PACE_COIN:     rsp_link.ready <= 1'($urandom_range(1, 0));
               PACE_MOSTLY:   rsp_link.ready <= ($urandom_range(4, 0) != 0);
               default:       rsp_link.ready <= (phase % 5 != 0) && (phase % 7 != 3);
            endcase
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         gap = ($urandom_range(2, 0) == 0 || hold_active) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            req_link.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_link.valid   <= 1'b1;
      req_link.rx_byte <= b;
      do @(posedge clock); while (!req_link.ready);
      bytes_sent++;
   endtask

   // mostly the usual position tag, sometimes any tag that is neither start nor end
   function automatic logic [3:0] data_tag(input int pos);
      logic [3:0] t;
      if ($urandom_range(3, 0) != 0) return 4'(pos + 1);
      do t = 4'($urandom); while (t == TAG_START || t == TAG_END);
      return t;
   endfunction

   // digit value 10 asks for a pattern that matches no digit
   function automatic void set_plan(input int d0, input int d1, input int d2, input int d3,
                                    input bit neg, input logic [2:0] dp, input bit micro,
                                    input bit milli, input logic [1:0] unit_bits);
      logic [6:0] seg;
      logic [3:0] mark;
      bit         hit;
      int         i;
      int         d;
      plan_digit[0] = d0;
      plan_digit[1] = d1;
      plan_digit[2] = d2;
      plan_digit[3] = d3;
      plan_neg      = neg;
      plan_dp       = dp;
      plan_micro    = micro;
      plan_milli    = milli;
      plan_unit     = unit_bits;
      // sign on the first digit, decimal points on the other three
      mark          = {plan_dp, plan_neg};
      for (i = 0; i < 4; i++) begin
         if (plan_digit[i] < 10) begin
            seg = seg_pattern(plan_digit[i]);
         end else begin
            forever begin
               seg = 7'($urandom);
               hit = 1'b0;
               for (d = 0; d < 10; d++)
                  if (seg == seg_pattern(d)) hit = 1'b1;
               if (!hit) break;
            end
         end
         frame_plan[1+2*i] = {mark[i], seg[6:4]};
         frame_plan[2+2*i] = seg[3:0];
      end
      // positions and bits the decoder ignores get fresh filler every time
      frame_plan[0]  = 4'($urandom);
      frame_plan[9]  = {plan_micro, 3'($urandom)};
      frame_plan[10] = {plan_milli, 3'($urandom)};
      frame_plan[11] = 4'($urandom);
      frame_plan[12] = {plan_unit, 2'($urandom)};
   endfunction

   function automatic void random_plan();
      int d [4];
      foreach (d[k]) d[k] = ($urandom_range(11, 0) == 0) ? 10 : $urandom_range(9, 0);
      set_plan(d[0], d[1], d[2], d[3], 1'($urandom), 3'($urandom), 1'($urandom),
               1'($urandom), 2'($urandom));
   endfunction

   task automatic send_frame(input frame_shape_type shape, input bit with_start);
      int skip_pos;
      int dup_pos;
      skip_pos = (shape == FRAME_SHORT) ? $urandom_range(12, 1) : -1;
      dup_pos  = (shape == FRAME_LONG) ? $urandom_range(12, 1) : -1;
      if (with_start) send_byte({TAG_START, frame_plan[0]});
      else            send_byte({data_tag(1), frame_plan[0]});
      for (int p = 1; p < 13; p++) begin
         if (p != skip_pos) send_byte({data_tag(p), frame_plan[p]});
         if (p == dup_pos)  send_byte({data_tag(p), frame_plan[p]});
      end
      send_byte({TAG_END, 4'($urandom)});
   endtask

   initial begin
      int  pick;
      bit  drained;
      tracker = new();
      drained = 1'b0;
      reset <= 1'b1;
      req_link.valid   <= 1'b0;
      req_link.rx_byte <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // headless frame straight after reset still counts from zero
      set_plan(0, 1, 2, 3, 1'b0, 3'b000, 1'b0, 1'b0, 2'b00);
      send_frame(FRAME_FULL, 1'b0);
      // same reading again, new filler: no change
      set_plan(0, 1, 2, 3, 1'b0, 3'b000, 1'b0, 1'b0, 2'b00);
      send_frame(FRAME_FULL, 1'b1);
      // every exponent mark, minus sign, amperes
      set_plan(4, 5, 6, 7, 1'b1, 3'b111, 1'b1, 1'b1, 2'b11);
      send_frame(FRAME_FULL, 1'b1);
      set_plan(9, 9, 9, 9, 1'b0, 3'b010, 1'b0, 1'b1, 2'b01);
      send_frame(FRAME_FULL, 1'b1);
      set_plan(8, 0, 0, 0, 1'b0, 3'b000, 1'b1, 1'b0, 2'b10);
      send_frame(FRAME_FULL, 1'b1);
      set_plan(0, 0, 0, 0, 1'b1, 3'b100, 1'b0, 1'b0, 2'b00);
      send_frame(FRAME_FULL, 1'b1);
      // unmatched segments
      set_plan(10, 0, 10, 10, 1'b0, 3'b001, 1'b0, 1'b0, 2'b01);
      send_frame(FRAME_FULL, 1'b1);
      send_frame(FRAME_SHORT, 1'b1);
      send_frame(FRAME_LONG, 1'b1);
      // count saturation, then two end bytes in a row
      repeat (20) send_byte({data_tag(3), 4'($urandom)});
      send_byte({TAG_END, 4'($urandom)});
      send_byte({TAG_END, 4'($urandom)});

      while (bytes_sent < 1200) begin
         if (!drained && bytes_sent >= 600) begin
            req_link.valid <= 1'b0;
            do @(posedge clock); while (tracker.due.size() != 0);
            drained = 1'b1;
         end
         pick = $urandom_range(99, 0);
         if (pick < 60) begin
            // a repeat of the last plan keeps changed low when that plan gave the last reading
            if ($urandom_range(3, 0) == 0)
               set_plan(plan_digit[0], plan_digit[1], plan_digit[2], plan_digit[3],
                        plan_neg, plan_dp, plan_micro, plan_milli, plan_unit);
            else
               random_plan();
            send_frame(FRAME_FULL, 1'b1);
         end else if (pick < 75) begin
            random_plan();
            send_frame(($urandom_range(1, 0) == 0) ? FRAME_SHORT : FRAME_LONG, 1'b1);
         end else if (pick < 85) begin
            // abandoned frame, restarted by a fresh start byte
            send_byte({TAG_START, 4'($urandom)});
            repeat ($urandom_range(10, 0)) send_byte({data_tag($urandom_range(12, 1)),
                                                      4'($urandom)});
            random_plan();
            send_frame(FRAME_FULL, 1'b1);
         end else if (pick < 95) begin
            repeat ($urandom_range(20, 1)) send_byte(8'($urandom));
         end else begin
            random_plan();
            send_frame(FRAME_FULL, 1'b0);
         end
      end

      req_link.valid <= 1'b0;
      do @(posedge clock); while (tracker.due.size() != 0);
      repeat (8) @(posedge clock);
      if (tracker.faults == 0 && tracker.due.size() == 0)
         $display("dmm_lcd_frame_decoder_unit: match");
      else
         $display("dmm_lcd_frame_decoder_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
